/* rtl/wrs_pkg.sv */
// Shared constants, state type and controller/datapath interface structs.
`default_nettype none
package wrs_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int WEIGHT_BITS_DEF   = 16;

  localparam int IDX_W       = 6;   // entry and range index fields
  localparam int IN_WEIGHT_W = 16;  // weight_value field
  localparam int RND_W       = 32;  // random_word field
  localparam int TOTAL_OUT_W = 22;  // range_total field
  localparam int MOD_CNT_W   = $clog2(RND_W);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MOD,
    ST_FIND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;     // capture the input word
    logic sum_step;   // walk the range, accumulate the total
    logic mod_init;   // restart the walk, clear the remainder
    logic mod_step;   // one restoring-division step
    logic find_step;  // walk the range, accumulate the running sum
    logic pick_load;  // latch the index of the current entry
    logic out_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic total_zero;
    logic mod_last;
    logic found;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* rtl/wrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/wrs_ctrl.sv */
// Sequencer for the sum, modulo, search and result phases of a draw.
`default_nettype none
module wrs_ctrl
  import wrs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    kind,
  input  wire status_t status,
  output logic         in_stall,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (kind == KIND_DRAW)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.walk_done) begin
          state_next = status.total_zero ? ST_FINISH : ST_MOD;
        end
      end
      ST_MOD: begin
        if (status.mod_last) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        if (status.found || status.walk_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        cmd.mod_init = status.walk_done && !status.total_zero;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      ST_FIND: begin
        cmd.find_step = 1'b1;
        cmd.pick_load = status.found;
      end
      ST_FINISH: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/wrs_datapath.sv */
// Weight table, range walker, modulo unit and output register.
`default_nettype none
module wrs_datapath
  import wrs_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  input  wire logic                   kind,
  input  wire logic [IDX_W-1:0]       entry_index,
  input  wire logic [IN_WEIGHT_W-1:0] weight_value,
  input  wire logic [IDX_W-1:0]       range_first,
  input  wire logic [IDX_W-1:0]       range_last,
  input  wire logic [RND_W-1:0]       random_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [IDX_W-1:0]            chosen_index,
  output logic                        empty_res,
  output logic [TOTAL_OUT_W-1:0]      range_total
);

  // Only entries reachable through a 6-bit index are stored.
  localparam int IDX_SPAN   = 1 << IDX_W;
  localparam int DEPTH      = (TABLE_ENTRIES < IDX_SPAN) ? TABLE_ENTRIES : IDX_SPAN;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int TOTAL_W    = WEIGHT_BITS + IDX_W;
  localparam int PTR_W      = IDX_W + 1;

  logic [DEPTH-1:0]       valid;
  logic                   ram_we;
  logic [WEIGHT_BITS-1:0] rdata;
  logic [ADDR_W-1:0]      raddr;

  logic [IDX_W-1:0]       first_r;
  logic [IDX_W-1:0]       last_r;
  logic [RND_W-1:0]       rnd_sh;
  logic [PTR_W-1:0]       issue_idx;
  logic [IDX_W-1:0]       data_idx;
  logic                   pend;
  logic                   data_ok;
  logic [TOTAL_W-1:0]     total;
  logic [TOTAL_W-1:0]     run;
  logic [TOTAL_W-1:0]     rem;
  logic [MOD_CNT_W-1:0]   mod_cnt;
  logic [IDX_W-1:0]       pick;

  logic                   walk_step;
  logic                   issue_ok;
  logic                   issue_in_tab;
  logic                   widx_in_tab;
  logic [WEIGHT_BITS-1:0] weight;
  logic [TOTAL_W-1:0]     run_sum;
  logic [TOTAL_W:0]       rem_sh;
  logic                   rem_ge;
  logic                   total_zero;

  assign walk_step    = cmd.sum_step || cmd.find_step;
  assign issue_ok     = issue_idx <= {1'b0, last_r};
  assign issue_in_tab = issue_idx < PTR_W'(DEPTH);
  assign widx_in_tab  = {1'b0, entry_index} < PTR_W'(DEPTH);
  assign raddr        = issue_idx[ADDR_W-1:0];
  assign ram_we       = cmd.accept && (kind == KIND_WRITE) && widx_in_tab;
  assign weight       = (pend && data_ok) ? rdata : '0;
  assign run_sum      = run + TOTAL_W'(weight);
  assign rem_sh       = {rem, rnd_sh[RND_W-1]};
  assign rem_ge       = rem_sh >= {1'b0, total};
  assign total_zero   = total == '0;

  assign status.walk_done  = !pend && !issue_ok;
  assign status.total_zero = total_zero;
  assign status.mod_last   = mod_cnt == '1;
  assign status.found      = pend && (rem < run_sum);
  assign status.out_free   = !out_valid || !out_stall;

  wrs_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index[ADDR_W-1:0]),
    .wdata (WEIGHT_BITS'(weight_value)),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[entry_index[ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.accept || cmd.mod_init) begin
      pend <= 1'b0;
    end else if (walk_step) begin
      pend <= issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      first_r   <= range_first;
      last_r    <= range_last;
      rnd_sh    <= random_word;
      issue_idx <= {1'b0, range_first};
      total     <= '0;
    end else if (cmd.mod_init) begin
      issue_idx <= {1'b0, first_r};
      run       <= '0;
      rem       <= '0;
      mod_cnt   <= '0;
      pick      <= last_r;
    end else begin
      if (walk_step && issue_ok) begin
        issue_idx <= issue_idx + PTR_W'(1);
        data_idx  <= issue_idx[IDX_W-1:0];
        data_ok   <= issue_in_tab && valid[raddr];
      end
      if (cmd.sum_step) begin
        total <= total + TOTAL_W'(weight);
      end
      if (cmd.find_step) begin
        run <= run_sum;
      end
      if (cmd.mod_step) begin
        rem     <= rem_ge ? TOTAL_W'(rem_sh - {1'b0, total}) : TOTAL_W'(rem_sh);
        rnd_sh  <= {rnd_sh[RND_W-2:0], 1'b0};
        mod_cnt <= mod_cnt + MOD_CNT_W'(1);
      end
      if (cmd.pick_load) begin
        pick <= data_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      chosen_index <= total_zero ? '0 : pick;
      empty_res    <= total_zero;
      range_total  <= TOTAL_OUT_W'(total);
    end
  end

endmodule
`default_nettype wire

/* rtl/weighted_random_select_unit.sv */
// Top level of the weighted random selection (roulette wheel) unit.
//
// Input channel (in_valid / in_stall): each word is either a table write
// (kind = write) that stores weight_value at entry_index, or a draw
// (kind = draw) over the inclusive range range_first..range_last using
// random_word as raw random bits. Writes beyond the table are dropped;
// range entries beyond the table count as weight zero.
// Output channel (out_valid / out_stall): one word per draw, none per write:
// chosen_index, empty_res (inverted range or zero total) and range_total.
// Sequence: a draw sums the weights over its range, reduces the random word
// modulo the total in the bit-serial modulo unit, runs the cumulative search
// until the pick is found and hands off the result; an empty draw skips the
// modulo and search phases. The table has one read port, so each walk
// reads one entry per cycle; the modulo unit resolves one quotient bit
// per cycle. One word is worked on at a time.
// A finished result sits in the output register, so the next input word is
// taken while the receiver stalls; a second result waits until it is free.
// Reset clears the controller, the output valid and every table entry's valid bit.
`default_nettype none
module weighted_random_select_unit
  import wrs_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   kind,
  input  wire logic [IDX_W-1:0]       entry_index,
  input  wire logic [IN_WEIGHT_W-1:0] weight_value,
  input  wire logic [IDX_W-1:0]       range_first,
  input  wire logic [IDX_W-1:0]       range_last,
  input  wire logic [RND_W-1:0]       random_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [IDX_W-1:0]            chosen_index,
  output logic                        empty_res,
  output logic [TOTAL_OUT_W-1:0]      range_total
);

  cmd_t    cmd;
  status_t status;

  // Controller: accepts words in idle, then for a draw steps the datapath through
  // the sum walk, the modulo reduction, the search walk and the result hand-off.
  wrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath: weight RAM, walk pointers, accumulators, remainder and the
  // output register.
  wrs_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .entry_index  (entry_index),
    .weight_value (weight_value),
    .range_first  (range_first),
    .range_last   (range_last),
    .random_word  (random_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_index (chosen_index),
    .empty_res    (empty_res),
    .range_total  (range_total)
  );

`ifndef ASSERT_OFF
  // An accepted word never produces a result in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !cmd.out_load)
    else $error("result loaded right after an input word was accepted");

  // The output register is only overwritten when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // An empty result carries zero index and zero total.
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (chosen_index == '0 && range_total == '0))
    else $error("empty result with nonzero fields");
`endif

endmodule
`default_nettype wire
